// ----- design/md4_hash_engine_assert.svh -----
// ----------------------------------------------------------------------------
// md4_hash_engine_assert.svh
// Assertion macros used by the MD4 engine back end. Each macro expects the
// signals clk and arst_n to be visible where it is used.
// ----------------------------------------------------------------------------
`ifndef MD4_HASH_ENGINE_ASSERT_SVH
`define MD4_HASH_ENGINE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define MD4_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define MD4_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/md4_pkg.sv -----
// ----------------------------------------------------------------------------
// md4_pkg
// Shared types, constants and step functions of the MD4 hash engine.
// ----------------------------------------------------------------------------
package md4_pkg;

	// Chaining word initial values and round constants
	localparam logic [31:0] INIT_A   = 32'h67452301;
	localparam logic [31:0] INIT_B   = 32'hefcdab89;
	localparam logic [31:0] INIT_C   = 32'h98badcfe;
	localparam logic [31:0] INIT_D   = 32'h10325476;
	localparam logic [31:0] K_ROUND2 = 32'h5a827999;
	localparam logic [31:0] K_ROUND3 = 32'h6ed9eba1;
	localparam logic [7:0]  PAD_BYTE = 8'h80;

	// Default depth of the command queue between front and back
	localparam int QUEUE_DEPTH = 4;

	// Input transaction
	typedef struct packed {
		logic       command;
		logic [7:0] data_byte;
	} md4_in_t;

	// Output transaction
	typedef struct packed {
		logic [31:0] digest_word_0;
		logic [31:0] digest_word_1;
		logic [31:0] digest_word_2;
		logic [31:0] digest_word_3;
	} md4_out_t;

	// Item class decided by the front end
	typedef enum logic {
		KIND_ABSORB = 1'b0,
		KIND_FINISH = 1'b1
	} md4_kind_t;

	// Queue entry
	typedef struct packed {
		md4_kind_t  kind;
		logic [7:0] data_byte;
	} md4_entry_t;

	// Message word used by a step: straight, column order, bit-reversed order
	function automatic logic [3:0] word_index(input logic [5:0] step);
		logic [3:0] idx;
		idx = step[3:0];
		case (step[5:4])
			2'd0: word_index = idx;
			2'd1: word_index = {idx[1:0], idx[3:2]};
			2'd2: word_index = {idx[0], idx[1], idx[2], idx[3]};
			default: word_index = idx;
		endcase
	endfunction

	// Left rotation amount of a step
	function automatic logic [4:0] rot_amount(input logic [5:0] step);
		logic [3:0] key;
		key = {step[5:4], step[1:0]};
		case (key)
			4'b0000: rot_amount = 5'd3;
			4'b0001: rot_amount = 5'd7;
			4'b0010: rot_amount = 5'd11;
			4'b0011: rot_amount = 5'd19;
			4'b0100: rot_amount = 5'd3;
			4'b0101: rot_amount = 5'd5;
			4'b0110: rot_amount = 5'd9;
			4'b0111: rot_amount = 5'd13;
			4'b1000: rot_amount = 5'd3;
			4'b1001: rot_amount = 5'd9;
			4'b1010: rot_amount = 5'd11;
			4'b1011: rot_amount = 5'd15;
			default: rot_amount = 5'd3;
		endcase
	endfunction

	// Round function plus round constant
	function automatic logic [31:0] round_mix(input logic [1:0] round,
		input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
		case (round)
			2'd0: round_mix = (x & y) | (~x & z);
			2'd1: round_mix = ((x & y) | (x & z) | (y & z)) + K_ROUND2;
			default: round_mix = (x ^ y ^ z) + K_ROUND3;
		endcase
	endfunction

	// Rotate left by a nonzero amount
	function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] s);
		logic [63:0] wide;
		wide = {x, x} << s;
		rotl32 = wide[63:32];
	endfunction

endpackage

// ----- design/md4_front.sv -----
// ----------------------------------------------------------------------------
// md4_front
// Accepts command transactions, classifies them and holds them in a short
// queue until the back end takes them.
// ----------------------------------------------------------------------------
module md4_front #(
	parameter int DEPTH = md4_pkg::QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_ready,
	input  md4_pkg::md4_in_t    cmd,
	output logic                q_valid,
	output md4_pkg::md4_entry_t q_entry,
	input  logic                q_pop
);
	import md4_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	md4_entry_t             queue_q [DEPTH];
	logic       [PTR_W-1:0] wr_ptr_q;
	logic       [PTR_W-1:0] rd_ptr_q;
	logic       [CNT_W-1:0] count_q;
	logic                   push;
	logic                   pop;
	md4_entry_t             entry_in;

	// Classify the incoming transaction
	always_comb begin
		entry_in.kind      = cmd.command ? KIND_FINISH : KIND_ABSORB;
		entry_in.data_byte = cmd.data_byte;
	end

	assign cmd_ready = (count_q != CNT_W'(DEPTH));
	assign push      = cmd_valid && cmd_ready;
	assign q_valid   = (count_q != '0);
	assign pop       = q_pop && q_valid;
	assign q_entry   = queue_q[rd_ptr_q];

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Store the entry
	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= entry_in;
		end
	end

endmodule

// ----- design/md4_back.sv -----
// ----------------------------------------------------------------------------
// md4_back
// Block buffer, padding sequencer and 48-step compression loop. Holds the
// chaining words and drives the digest output register.
// ----------------------------------------------------------------------------
`include "md4_hash_engine_assert.svh"

module md4_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	input  md4_pkg::md4_entry_t q_entry,
	output logic                q_pop,
	output logic                digest_valid,
	input  logic                digest_ready,
	output md4_pkg::md4_out_t   digest
);
	import md4_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_PAD  = 7'b0000010,
		S_LEN  = 7'b0000100,
		S_LOAD = 7'b0001000,
		S_COMP = 7'b0010000,
		S_DONE = 7'b0100000,
		S_EMIT = 7'b1000000
	} md4_state_t;

	typedef enum logic [2:0] {
		PH_DATA = 3'b001,
		PH_PAD  = 3'b010,
		PH_LEN  = 3'b100
	} md4_phase_t;

	md4_state_t  state_q;
	md4_phase_t  phase_q;
	logic [5:0]  fill_q;
	logic [63:0] bit_len_q;
	logic        pad_first_q;
	logic [5:0]  step_q;
	logic [31:0] chain_q [4];
	logic        out_valid_q;

	logic [63:0] len_q;
	logic [31:0] word_q;
	logic [31:0] mem [16];
	logic [31:0] w_q;
	logic [31:0] a_q, b_q, c_q, d_q;
	md4_out_t    digest_q;

	logic        push_en;
	logic [7:0]  push_val;
	logic [3:0]  rd_addr;
	logic [31:0] step_sum;
	logic [31:0] a_next;
	logic        emit_load;

	// Select the byte going into the block buffer
	always_comb begin
		push_en  = 1'b0;
		push_val = '0;
		case (state_q)
			S_IDLE: begin
				if (q_valid && q_entry.kind == KIND_ABSORB) begin
					push_en  = 1'b1;
					push_val = q_entry.data_byte;
				end
			end
			S_PAD: begin
				push_en  = 1'b1;
				push_val = pad_first_q ? PAD_BYTE : 8'h00;
			end
			S_LEN: begin
				push_en  = 1'b1;
				push_val = len_q[7:0];
			end
			default: begin
				push_en = 1'b0;
			end
		endcase
	end

	assign q_pop = (state_q == S_IDLE) && q_valid;

	// Prefetch the message word of the next step
	always_comb begin
		case (state_q)
			S_LOAD:  rd_addr = word_index(6'd0);
			S_COMP:  rd_addr = word_index(step_q + 6'd1);
			default: rd_addr = '0;
		endcase
	end

	// One compression step
	assign step_sum = a_q + round_mix(step_q[5:4], b_q, c_q, d_q) + w_q;
	assign a_next   = rotl32(step_sum, rot_amount(step_q));

	assign emit_load = (state_q == S_EMIT) && (!out_valid_q || digest_ready);

	// Sequence bytes, padding, compression and digest hand-off
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= PH_DATA;
			fill_q      <= '0;
			bit_len_q   <= '0;
			pad_first_q <= 1'b0;
			step_q      <= '0;
			chain_q[0]  <= INIT_A;
			chain_q[1]  <= INIT_B;
			chain_q[2]  <= INIT_C;
			chain_q[3]  <= INIT_D;
			out_valid_q <= 1'b0;
		end else begin
			if (emit_load) begin
				out_valid_q <= 1'b1;
			end else if (digest_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						if (q_entry.kind == KIND_ABSORB) begin
							bit_len_q <= bit_len_q + 64'd8;
							fill_q    <= fill_q + 6'd1;
							if (fill_q == 6'd63) begin
								state_q <= S_LOAD;
							end
						end else begin
							phase_q     <= PH_PAD;
							pad_first_q <= 1'b1;
							state_q     <= S_PAD;
						end
					end
				end
				S_PAD: begin
					fill_q      <= fill_q + 6'd1;
					pad_first_q <= 1'b0;
					if (fill_q == 6'd63) begin
						state_q <= S_LOAD;
					end else if (fill_q == 6'd55) begin
						phase_q <= PH_LEN;
						state_q <= S_LEN;
					end
				end
				S_LEN: begin
					fill_q <= fill_q + 6'd1;
					if (fill_q == 6'd63) begin
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					step_q  <= '0;
					state_q <= S_COMP;
				end
				S_COMP: begin
					step_q <= step_q + 6'd1;
					if (step_q == 6'd47) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					chain_q[0] <= chain_q[0] + a_q;
					chain_q[1] <= chain_q[1] + b_q;
					chain_q[2] <= chain_q[2] + c_q;
					chain_q[3] <= chain_q[3] + d_q;
					case (phase_q)
						PH_PAD:  state_q <= S_PAD;
						PH_LEN:  state_q <= S_EMIT;
						default: state_q <= S_IDLE;
					endcase
				end
				S_EMIT: begin
					if (emit_load) begin
						chain_q[0]  <= INIT_A;
						chain_q[1]  <= INIT_B;
						chain_q[2]  <= INIT_C;
						chain_q[3]  <= INIT_D;
						bit_len_q   <= '0;
						phase_q     <= PH_DATA;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath: word packing, length shifter, working variables, digest
	always_ff @(posedge clk) begin
		if (push_en) begin
			word_q <= {push_val, word_q[31:8]};
		end
		if (q_pop && q_entry.kind == KIND_FINISH) begin
			len_q <= bit_len_q;
		end else if (state_q == S_LEN) begin
			len_q <= {8'h00, len_q[63:8]};
		end
		if (state_q == S_LOAD) begin
			a_q <= chain_q[0];
			b_q <= chain_q[1];
			c_q <= chain_q[2];
			d_q <= chain_q[3];
		end else if (state_q == S_COMP) begin
			a_q <= d_q;
			b_q <= a_next;
			c_q <= b_q;
			d_q <= c_q;
		end
		if (emit_load) begin
			digest_q.digest_word_0 <= chain_q[0];
			digest_q.digest_word_1 <= chain_q[1];
			digest_q.digest_word_2 <= chain_q[2];
			digest_q.digest_word_3 <= chain_q[3];
		end
	end

	// Block buffer: write a packed word every fourth byte, registered read
	always_ff @(posedge clk) begin
		if (push_en && fill_q[1:0] == 2'd3) begin
			mem[fill_q[5:2]] <= {push_val, word_q[31:8]};
		end
		w_q <= mem[rd_addr];
	end

	assign digest_valid = out_valid_q;
	assign digest       = digest_q;

	`MD4_ASSERT_NOW(a_load_block_full, state_q == S_LOAD, fill_q == 6'd0, "compression started on a partial block")
	`MD4_ASSERT_NEXT(a_comp_exit, (state_q == S_COMP) && (step_q == 6'd47), state_q == S_DONE, "compression did not end after 48 steps")
	`MD4_ASSERT_NOW(a_len_window, state_q == S_LEN, fill_q >= 6'd56, "length bytes written outside the last eight bytes")
	`MD4_ASSERT_NEXT(a_emit_clears, emit_load, (fill_q == 6'd0) && (bit_len_q == 64'd0), "engine not returned to start of message after digest")

endmodule

// ----- design/md4_hash_engine.sv -----
// ----------------------------------------------------------------------------
// md4_hash_engine
// Byte-serial MD4 message digest. Absorb transactions append message bytes;
// a finish transaction pads, compresses and returns the 128-bit digest.
// ----------------------------------------------------------------------------
//  channel  direction  payload     handshake
//  cmd      in         md4_in_t    cmd_valid / cmd_ready
//  digest   out        md4_out_t   digest_valid / digest_ready
//
//  The back end takes absorb bytes from the queue while idle; every 64th byte
//  starts a word prefetch, 48 compression steps and a chaining add on the shared
//  step unit, during which the command queue keeps accepting while it has room.
//  A finish leaves the queue, then 9 to 72 padding/length bytes are written,
//  with one or two compressions, and the digest register is loaded.
//  Reset clears the control state and loads the MD4 initial chaining words.
//  A stalled digest holds the back end only once a second digest is ready.
// ----------------------------------------------------------------------------
module md4_hash_engine #(
	parameter int QUEUE_DEPTH = md4_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_ready,
	input  md4_pkg::md4_in_t  cmd,
	output logic              digest_valid,
	input  logic              digest_ready,
	output md4_pkg::md4_out_t digest
);
	import md4_pkg::*;

	logic       q_valid;
	logic       q_pop;
	md4_entry_t q_entry;

	// Front end: accept and queue commands
	md4_front #(
		.DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd      (cmd),
		.q_valid  (q_valid),
		.q_entry  (q_entry),
		.q_pop    (q_pop)
	);

	// Back end: buffer, pad, compress, emit
	md4_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_entry     (q_entry),
		.q_pop       (q_pop),
		.digest_valid(digest_valid),
		.digest_ready(digest_ready),
		.digest      (digest)
	);

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the byte-serial MD4 engine. Messages of directed
// and random lengths are streamed as absorb transactions closed by a finish.
// Every accepted command feeds an in-bench MD4 predictor, and each returned
// digest is checked word by word against the oldest predicted digest. Both
// channels idle at random, and the receiver holds off once for a long time.
// ----------------------------------------------------------------------------
module tb_top;
	import md4_pkg::*;

	localparam int ITEM_TARGET   = 1850;
	localparam int HOLD_AT       = 6;
	localparam int HOLD_CYCLES   = 4000;
	localparam int STALL_LIMIT   = 20000;
	localparam int DRAIN_CYCLES  = 300;

	// MD4 predictor with a queue of digests not yet returned
	class md4_digest_board;
		logic [31:0] chain [4];
		logic [7:0]  msg_buf [64];
		int unsigned fill;
		logic [63:0] bit_count;
		md4_out_t    pending_digests [$];
		int unsigned mismatches;

		function new();
			mismatches = 0;
			restart();
		endfunction

		// Reload the initial chaining words for a new message
		function void restart();
			chain[0] = INIT_A;
			chain[1] = INIT_B;
			chain[2] = INIT_C;
			chain[3] = INIT_D;
			fill = 0;
			bit_count = '0;
		endfunction

		function logic [31:0] rol(input logic [31:0] x, input int s);
			return (x << s) | (x >> (32 - s));
		endfunction

		// Run the 48 steps over the full block and fold into the chain
		function void compress();
			logic [31:0] w [16];
			logic [31:0] a, b, c, d, f, t;
			logic [3:0]  j;
			int          i, r, k, s;
			for (i = 0; i < 16; i++)
				w[i] = {msg_buf[4*i+3], msg_buf[4*i+2], msg_buf[4*i+1], msg_buf[4*i]};
			a = chain[0];
			b = chain[1];
			c = chain[2];
			d = chain[3];
			for (i = 0; i < 48; i++) begin
				r = i / 16;
				j = 4'(i % 16);
				case (r)
					0: begin
						f = (b & c) | (~b & d);
						k = int'(j);
						s = (i % 4 == 0) ? 3 : (i % 4 == 1) ? 7 : (i % 4 == 2) ? 11 : 19;
					end
					1: begin
						f = ((b & c) | (b & d) | (c & d)) + K_ROUND2;
						k = int'(j % 4) * 4 + int'(j / 4);
						s = (i % 4 == 0) ? 3 : (i % 4 == 1) ? 5 : (i % 4 == 2) ? 9 : 13;
					end
					default: begin
						f = (b ^ c ^ d) + K_ROUND3;
						k = int'({j[0], j[1], j[2], j[3]});
						s = (i % 4 == 0) ? 3 : (i % 4 == 1) ? 9 : (i % 4 == 2) ? 11 : 15;
					end
				endcase
				t = rol(a + f + w[k], s);
				a = d;
				d = c;
				c = b;
				b = t;
			end
			chain[0] += a;
			chain[1] += b;
			chain[2] += c;
			chain[3] += d;
		endfunction

		function void append(input logic [7:0] value);
			msg_buf[fill] = value;
			fill++;
			if (fill == 64) begin
				compress();
				fill = 0;
			end
		endfunction

		// Advance the predictor by one accepted command
		function void note_command(input md4_in_t item);
			logic [63:0] length;
			int          i;
			if (md4_kind_t'(item.command) == KIND_ABSORB) begin
				bit_count += 64'd8;
				append(item.data_byte);
			end else begin
				length = bit_count;
				append(PAD_BYTE);
				while (fill != 56)
					append(8'h00);
				for (i = 0; i < 8; i++)
					append(length[8*i +: 8]);
				pending_digests.push_back({chain[0], chain[1], chain[2], chain[3]});
				restart();
			end
		endfunction

		// Compare a returned digest with the oldest prediction
		function void check_digest(input md4_out_t got);
			md4_out_t want;
			if (pending_digests.size() == 0) begin
				$error("unexpected digest %h with no finish outstanding", got);
				mismatches++;
				return;
			end
			want = pending_digests.pop_front();
			if (got.digest_word_0 !== want.digest_word_0) begin
				$error("digest_word_0: expected %h, got %h", want.digest_word_0,
					got.digest_word_0);
				mismatches++;
			end
			if (got.digest_word_1 !== want.digest_word_1) begin
				$error("digest_word_1: expected %h, got %h", want.digest_word_1,
					got.digest_word_1);
				mismatches++;
			end
			if (got.digest_word_2 !== want.digest_word_2) begin
				$error("digest_word_2: expected %h, got %h", want.digest_word_2,
					got.digest_word_2);
				mismatches++;
			end
			if (got.digest_word_3 !== want.digest_word_3) begin
				$error("digest_word_3: expected %h, got %h", want.digest_word_3,
					got.digest_word_3);
				mismatches++;
			end
		endfunction

		function int unsigned outstanding();
			return pending_digests.size();
		endfunction
	endclass

	logic     clk;
	logic     arst_n;
	logic     cmd_valid;
	logic     cmd_ready;
	md4_in_t  cmd;
	logic     digest_valid;
	logic     digest_ready;
	md4_out_t digest;

	md4_digest_board board;
	int unsigned     items_sent;
	int unsigned     digests_taken;
	int unsigned     stall_count;
	bit              tx_gaps;
	bit              rx_gaps;

	md4_hash_engine u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd_ready    (cmd_ready),
		.cmd          (cmd),
		.digest_valid (digest_valid),
		.digest_ready (digest_ready),
		.digest       (digest)
	);

	// Free-running clock, 20 ns period
	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Offer one command and hold it until the transaction completes
	task automatic push_cmd(input md4_kind_t kind, input logic [7:0] value);
		int gap;
		gap = tx_gaps ? $urandom_range(0, 14) : 0;
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd.command   <= kind;
		cmd.data_byte <= value;
		cmd_valid     <= 1'b1;
		@(posedge clk);
		while (!cmd_ready)
			@(posedge clk);
		board.note_command('{command: kind, data_byte: value});
		items_sent++;
	endtask

	// Stream a message of random bytes and close it with a finish
	task automatic send_message(input int unsigned length);
		int unsigned i;
		logic [7:0]  value;
		tx_gaps = ($urandom_range(0, 3) != 0);
		for (i = 0; i < length; i++) begin
			case ($urandom_range(0, 7))
				0: value = 8'h00;
				1: value = 8'hff;
				default: value = 8'($urandom_range(0, 255));
			endcase
			push_cmd(KIND_ABSORB, value);
		end
		push_cmd(KIND_FINISH, 8'($urandom_range(0, 255)));
	endtask

	// Favor lengths around the padding and block boundaries
	function automatic int unsigned pick_length();
		int unsigned sel;
		sel = $urandom_range(0, 15);
		if (sel < 7) begin
			case ($urandom_range(0, 12))
				0: return 1;
				1: return 54;
				2: return 55;
				3: return 56;
				4: return 57;
				5: return 62;
				6: return 63;
				7: return 64;
				8: return 65;
				9: return 118;
				10: return 119;
				11: return 120;
				default: return 128;
			endcase
		end
		if (sel < 15)
			return $urandom_range(0, 70);
		return $urandom_range(100, 200);
	endfunction

	// Stimulus: reset, directed messages, random messages, drain
	initial begin
		board         = new();
		items_sent    = 0;
		tx_gaps       = 1'b0;
		arst_n        <= 1'b0;
		cmd_valid     <= 1'b0;
		cmd           <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty message, with the ignored byte at both extremes
		push_cmd(KIND_FINISH, 8'h00);
		push_cmd(KIND_FINISH, 8'hff);
		// Single-byte extremes
		push_cmd(KIND_ABSORB, 8'h00);
		push_cmd(KIND_FINISH, 8'h00);
		push_cmd(KIND_ABSORB, 8'hff);
		push_cmd(KIND_FINISH, 8'h55);
		// "abc"
		tx_gaps = 1'b1;
		push_cmd(KIND_ABSORB, 8'h61);
		push_cmd(KIND_ABSORB, 8'h62);
		push_cmd(KIND_ABSORB, 8'h63);
		push_cmd(KIND_FINISH, 8'haa);
		// Mixed bit patterns
		push_cmd(KIND_ABSORB, 8'h80);
		push_cmd(KIND_ABSORB, 8'h01);
		push_cmd(KIND_ABSORB, 8'h7f);
		push_cmd(KIND_ABSORB, 8'hfe);
		push_cmd(KIND_FINISH, 8'h00);

		while (items_sent < ITEM_TARGET)
			send_message(pick_length());
		cmd_valid <= 1'b0;

		while (board.outstanding() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.mismatches == 0)
			$display("md4_hash_engine test passed");
		else
			$display("md4_hash_engine test failed");
		$finish;
	end

	// Digest receiver: random gaps, one long hold-off to back the engine up
	initial begin
		int gap;
		digests_taken = 0;
		rx_gaps       = 1'b1;
		digest_ready  <= 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (digests_taken == HOLD_AT)
				gap = HOLD_CYCLES;
			else
				gap = rx_gaps ? $urandom_range(0, 14) : 0;
			if (gap > 0) begin
				digest_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			digest_ready <= 1'b1;
			@(posedge clk);
			while (!digest_valid)
				@(posedge clk);
			board.check_digest(digest);
			digests_taken++;
			if ($urandom_range(0, 7) == 0)
				rx_gaps = ~rx_gaps;
		end
	end

	// Watchdog: end the run when no transaction moves for too long
	always @(posedge clk) begin
		if ((cmd_valid && cmd_ready) || (digest_valid && digest_ready))
			stall_count = 0;
		else
			stall_count++;
		if (stall_count >= STALL_LIMIT) begin
			$display("md4_hash_engine test failed");
			$finish;
		end
	end

	initial stall_count = 0;

endmodule

// ----- files.f -----
+incdir+design
design/md4_pkg.sv
design/md4_front.sv
design/md4_back.sv
design/md4_hash_engine.sv
bench/tb_top.sv
